>>> rtl/core/whct_pkg.sv
// Shared types and constants for the WAV header check and transform block.
package whct_pkg;

    // Header length in bytes and top value of the saturating counters
    localparam logic [33:0] HDR_LEN = 34'd44;
    localparam logic [33:0] POS_MAX = 34'h3_FFFF_FFFF;

    // Tags as little-endian words (first stream byte in bits 7:0)
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Mode register codes
    localparam logic [2:0] MODE_CHECK  = 3'd0;
    localparam logic [2:0] MODE_HALVE  = 3'd1;
    localparam logic [2:0] MODE_DOUBLE = 3'd2;
    localparam logic [2:0] MODE_LEFT   = 3'd3;
    localparam logic [2:0] MODE_RIGHT  = 3'd4;
    localparam logic [2:0] MODE_VOLUME = 3'd5;

    // Status codes
    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_RIFF       = 4'd1;
    localparam logic [3:0] ST_WAVE       = 4'd2;
    localparam logic [3:0] ST_FMT_TAG    = 4'd3;
    localparam logic [3:0] ST_FMT_SIZE   = 4'd4;
    localparam logic [3:0] ST_TYPE       = 4'd5;
    localparam logic [3:0] ST_CHANNELS   = 4'd6;
    localparam logic [3:0] ST_BYTERATE   = 4'd7;
    localparam logic [3:0] ST_BITS       = 4'd8;
    localparam logic [3:0] ST_ALIGN      = 4'd9;
    localparam logic [3:0] ST_DATA_TAG   = 4'd10;
    localparam logic [3:0] ST_SHORT_DATA = 4'd11;
    localparam logic [3:0] ST_FILE_SIZE  = 4'd12;
    localparam logic [3:0] ST_SHORT_HDR  = 4'd13;

    // Length of the rewritten mono header
    localparam logic [5:0] MONO_HDR_LEN = 6'd40;

    // Kind of result burst one input word causes
    typedef enum logic [2:0] {
        BK_NONE,
        BK_BYTE1,
        BK_BYTE2,
        BK_WORD4,
        BK_MONO,
        BK_STATUS
    } burst_kind_t;

    typedef struct packed {
        burst_kind_t kind;
        logic [31:0] val;
    } burst_t;

    // Captured header fields
    typedef struct packed {
        logic [31:0] riff_size;
        logic [31:0] fmt_size;
        logic [15:0] fmt_type;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] data_size;
    } hdr_t;

    // Number of result words in a burst
    function automatic logic [5:0] burst_len(burst_kind_t kind);
        logic [5:0] n;
        unique case (kind)
            BK_BYTE2: n = 6'd2;
            BK_WORD4: n = 6'd4;
            BK_MONO:  n = MONO_HDR_LEN;
            default:  n = 6'd1;
        endcase
        return n;
    endfunction

endpackage

>>> rtl/core/wav_header_check_and_transform_top.sv
// Top level of the WAV header check and transform block.
// Takes a canonical 44-byte PCM WAV stream one byte per input word and checks
// the header as it arrives, reporting the first error as a status word and
// then going quiet until reset. A word with end_of_stream set closes the file
// with a final status (short header, short data, file size, or ok). The mode
// register selects check only, halving or doubling of the rate fields, left
// or right channel extraction (40-byte mono header sent when header byte 44
// arrives), or volume scaling by one eighth. A new input word can be taken
// every cycle. The input stalls while the result register holds a word that
// out_ready has not yet taken; a multi-word burst (two, four or forty words)
// holds the input until all its words are taken, and the next input word can
// be taken in the cycle that the last word of the burst goes out. Write mode
// only while the block is idle.
module wav_header_check_and_transform_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [3:0] status,
    output logic       status_valid,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data
);

    logic [2:0]       mode_reg;
    logic [33:0]      pos_reg, pos_next;
    whct_pkg::hdr_t   hdr_reg, hdr_next;
    logic [33:0]      dbs_reg, dbs_next;
    logic [31:0]      extra_reg, extra_next;
    logic [7:0]       held_reg, held_next;
    logic             stop_reg, stop_next;
    whct_pkg::burst_t burst;
    logic             accept;
    logic             take_ok;
    logic [2:0]       m;
    logic [5:0]       p;
    logic [1:0]       sl;
    logic             in_hdr;
    logic [3:0]       err;
    logic [31:0]      tag_word;
    logic [47:0]      rate_prod;
    logic [16:0]      align_calc;
    logic [33:0]      size_sum;
    logic [1:0]       k2;
    logic             mono, eight, in_data;
    logic [15:0]      smp;
    logic signed [16:0] smp_adj;
    logic signed [16:0] smp_q;
    logic [31:0]      rate_v;

    assign accept    = in_valid && in_ready;
    assign in_ready  = take_ok;
    assign cfg_ready = 1'b1;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= whct_pkg::MODE_CHECK;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    assign m = (mode_reg > whct_pkg::MODE_VOLUME) ? whct_pkg::MODE_CHECK : mode_reg;

    // Header position decode
    assign in_hdr = (pos_reg <= whct_pkg::HDR_LEN);
    assign p      = pos_reg[5:0];
    assign sl     = 2'(p - 6'd1);

    assign tag_word   = (p <= 6'd4) ? whct_pkg::TAG_RIFF
                      : (p <= 6'd12) ? whct_pkg::TAG_WAVE : whct_pkg::TAG_FMT;
    assign rate_prod  = 48'(hdr_reg.sample_rate) * 48'(hdr_reg.block_align);
    assign align_calc = (hdr_reg.sample_bits == 16'd8) ? {1'b0, hdr_reg.channels}
                                                       : {hdr_reg.channels, 1'b0};
    assign size_sum   = 34'd36 + {2'b00, hdr_reg.data_size} + {2'b00, extra_reg};

    // Body decode
    assign k2      = pos_reg[1:0] + 2'd3;
    assign mono    = (hdr_reg.channels != 16'd2);
    assign eight   = (hdr_reg.sample_bits == 16'd8);
    assign in_data = (pos_reg - whct_pkg::HDR_LEN) <= {2'b00, hdr_reg.data_size};
    assign smp     = {in_byte, held_reg};
    assign smp_adj = $signed({smp[15], smp}) + (smp[15] ? 17'sd7 : 17'sd0);
    assign smp_q   = smp_adj >>> 3;

    // Next state and result burst for one input word
    always_comb
    begin
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        dbs_next   = dbs_reg;
        extra_next = extra_reg;
        held_next  = held_reg;
        stop_next  = stop_reg;
        err        = whct_pkg::ST_OK;
        rate_v     = '0;
        burst.kind = whct_pkg::BK_NONE;
        burst.val  = '0;

        if (stop_reg)
        begin
            burst.kind = whct_pkg::BK_NONE;
        end
        else if (end_of_stream)
        begin
            burst.kind = whct_pkg::BK_STATUS;
            stop_next  = 1'b1;
            if (in_hdr)
                burst.val = {28'd0, whct_pkg::ST_SHORT_HDR};
            else if (dbs_reg < {2'b00, hdr_reg.data_size})
                burst.val = {28'd0, whct_pkg::ST_SHORT_DATA};
            else if ({2'b00, hdr_reg.riff_size} != size_sum)
                burst.val = {28'd0, whct_pkg::ST_FILE_SIZE};
            else
                burst.val = {28'd0, whct_pkg::ST_OK};
        end
        else if (in_hdr)
        begin
            // Field capture and checks
            priority if (p <= 6'd16 && (p <= 6'd4 || p >= 6'd9))
            begin
                if (in_byte != tag_word[{sl, 3'b000} +: 8])
                    err = (p <= 6'd4) ? whct_pkg::ST_RIFF
                        : (p <= 6'd12) ? whct_pkg::ST_WAVE : whct_pkg::ST_FMT_TAG;
            end
            else if (p <= 6'd8)
                hdr_next.riff_size[{sl, 3'b000} +: 8] = in_byte;
            else if (p <= 6'd20)
                hdr_next.fmt_size[{sl, 3'b000} +: 8] = in_byte;
            else if (p <= 6'd22)
            begin
                if (p == 6'd21 && hdr_reg.fmt_size != 32'd16)
                    err = whct_pkg::ST_FMT_SIZE;
                else
                    hdr_next.fmt_type[{sl[0], 3'b000} +: 8] = in_byte;
            end
            else if (p <= 6'd24)
            begin
                if (p == 6'd23 && hdr_reg.fmt_type != 16'd1)
                    err = whct_pkg::ST_TYPE;
                else
                    hdr_next.channels[{sl[0], 3'b000} +: 8] = in_byte;
            end
            else if (p <= 6'd28)
            begin
                if (p == 6'd25 && hdr_reg.channels != 16'd1 && hdr_reg.channels != 16'd2)
                    err = whct_pkg::ST_CHANNELS;
                else
                    hdr_next.sample_rate[{sl, 3'b000} +: 8] = in_byte;
            end
            else if (p <= 6'd32)
                hdr_next.byte_rate[{sl, 3'b000} +: 8] = in_byte;
            else if (p <= 6'd34)
                hdr_next.block_align[{sl[0], 3'b000} +: 8] = in_byte;
            else if (p <= 6'd36)
            begin
                if (p == 6'd35 && rate_prod != {16'd0, hdr_reg.byte_rate})
                    err = whct_pkg::ST_BYTERATE;
                else
                    hdr_next.sample_bits[{sl[0], 3'b000} +: 8] = in_byte;
            end
            else if (p <= 6'd40)
            begin
                if (p == 6'd37 && hdr_reg.sample_bits != 16'd8
                        && hdr_reg.sample_bits != 16'd16)
                    err = whct_pkg::ST_BITS;
                else if (p == 6'd37 && align_calc != {1'b0, hdr_reg.block_align})
                    err = whct_pkg::ST_ALIGN;
                else if (in_byte != whct_pkg::TAG_DATA[{sl, 3'b000} +: 8])
                    err = whct_pkg::ST_DATA_TAG;
            end
            else
                hdr_next.data_size[{sl, 3'b000} +: 8] = in_byte;

            if (err != whct_pkg::ST_OK)
            begin
                burst.kind = whct_pkg::BK_STATUS;
                burst.val  = {28'd0, err};
                stop_next  = 1'b1;
            end
            else
            begin
                pos_next  = pos_reg + 34'd1;
                burst.val = {24'd0, in_byte};
                // Header echo per mode
                priority if (p <= 6'd4)
                begin
                    if (m != whct_pkg::MODE_CHECK)
                        burst.kind = whct_pkg::BK_BYTE1;
                end
                else if (p >= 6'd25 && p <= 6'd32)
                begin
                    rate_v = (p == 6'd28) ? hdr_next.sample_rate : hdr_next.byte_rate;
                    if (m == whct_pkg::MODE_VOLUME)
                        burst.kind = whct_pkg::BK_BYTE1;
                    else if ((m == whct_pkg::MODE_HALVE || m == whct_pkg::MODE_DOUBLE)
                            && (p == 6'd28 || p == 6'd32))
                    begin
                        burst.kind = whct_pkg::BK_WORD4;
                        burst.val  = (m == whct_pkg::MODE_HALVE) ? {1'b0, rate_v[31:1]}
                                                                 : {rate_v[30:0], 1'b0};
                    end
                end
                else if (m == whct_pkg::MODE_HALVE || m == whct_pkg::MODE_DOUBLE
                        || m == whct_pkg::MODE_VOLUME)
                    burst.kind = whct_pkg::BK_BYTE1;
                else if ((m == whct_pkg::MODE_LEFT || m == whct_pkg::MODE_RIGHT)
                        && p == 6'd44)
                    burst.kind = whct_pkg::BK_MONO;
            end
        end
        else
        begin
            // Data area and trailing bytes
            burst.val = {24'd0, in_byte};
            if (in_data)
            begin
                unique case (m)
                    whct_pkg::MODE_HALVE,
                    whct_pkg::MODE_DOUBLE:
                        burst.kind = whct_pkg::BK_BYTE1;
                    whct_pkg::MODE_LEFT:
                        if (mono || (eight ? !k2[0] : !k2[1]))
                            burst.kind = whct_pkg::BK_BYTE1;
                    whct_pkg::MODE_RIGHT:
                        if (mono || (eight ? k2[0] : k2[1]))
                            burst.kind = whct_pkg::BK_BYTE1;
                    whct_pkg::MODE_VOLUME:
                        if (eight)
                        begin
                            burst.kind = whct_pkg::BK_BYTE1;
                            burst.val  = {27'd0, in_byte[7:3]};
                        end
                        else if (!k2[0])
                            held_next = in_byte;
                        else
                        begin
                            burst.kind = whct_pkg::BK_BYTE2;
                            burst.val  = {16'd0, smp_q[15:0]};
                        end
                    default:
                        burst.kind = whct_pkg::BK_NONE;
                endcase
            end
            else
            begin
                if (extra_reg != 32'hFFFF_FFFF)
                    extra_next = extra_reg + 32'd1;
                if (m != whct_pkg::MODE_CHECK)
                    burst.kind = whct_pkg::BK_BYTE1;
            end
            if (dbs_reg < whct_pkg::POS_MAX)
                dbs_next = dbs_reg + 34'd1;
            if (pos_reg < whct_pkg::POS_MAX)
                pos_next = pos_reg + 34'd1;
        end
    end

    // Stream state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 34'd1;
            hdr_reg   <= '0;
            dbs_reg   <= '0;
            extra_reg <= '0;
            held_reg  <= '0;
            stop_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            dbs_reg   <= dbs_next;
            extra_reg <= extra_next;
            held_reg  <= held_next;
            stop_reg  <= stop_next;
        end
    end

    // Result register and serializer
    whct_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .burst_in     (burst),
        .hdr          (hdr_reg),
        .take_ok      (take_ok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .status       (status),
        .status_valid (status_valid),
        .last         (last)
    );

endmodule

>>> rtl/core/whct_out.sv
// Result register and burst serializer, including the mono header rewrite.
module whct_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  whct_pkg::burst_t burst_in,
    input  whct_pkg::hdr_t   hdr,
    output logic            take_ok,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic [3:0]      status,
    output logic            status_valid,
    output logic            last
);

    whct_pkg::burst_kind_t kind_reg;
    logic [31:0]           val_reg;
    logic [5:0]            idx_reg;
    logic                  last_beat;
    logic                  stereo;
    logic [31:0]           mono_word;
    logic [31:0]           src_word;

    assign last_beat = (idx_reg == whct_pkg::burst_len(kind_reg) - 6'd1);
    assign out_valid = (kind_reg != whct_pkg::BK_NONE);
    assign take_ok   = !out_valid || (out_ready && last_beat);

    // Burst register: load a new burst or step through the current one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= whct_pkg::BK_NONE;
            val_reg  <= '0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            kind_reg <= burst_in.kind;
            val_reg  <= burst_in.val;
            idx_reg  <= '0;
        end
        else if (out_valid && out_ready)
        begin
            if (last_beat)
            begin
                kind_reg <= whct_pkg::BK_NONE;
            end
            else
            begin
                idx_reg <= idx_reg + 6'd1;
            end
        end
    end

    // Mono header words; stereo halves data size, byte rate, block align
    assign stereo = (hdr.channels == 16'd2);

    always_comb
    begin
        unique case (idx_reg[5:2])
            4'd0: mono_word = stereo ? hdr.riff_size - {1'b0, hdr.data_size[31:1]}
                                     : hdr.riff_size;
            4'd1: mono_word = whct_pkg::TAG_WAVE;
            4'd2: mono_word = whct_pkg::TAG_FMT;
            4'd3: mono_word = hdr.fmt_size;
            4'd4: mono_word = {16'd1, hdr.fmt_type};
            4'd5: mono_word = hdr.sample_rate;
            4'd6: mono_word = stereo ? {1'b0, hdr.byte_rate[31:1]} : hdr.byte_rate;
            4'd7: mono_word = {hdr.sample_bits,
                               stereo ? {1'b0, hdr.block_align[15:1]} : hdr.block_align};
            4'd8: mono_word = whct_pkg::TAG_DATA;
            4'd9: mono_word = stereo ? {1'b0, hdr.data_size[31:1]} : hdr.data_size;
            default: mono_word = '0;
        endcase
    end

    // Output word fields
    always_comb
    begin
        src_word     = (kind_reg == whct_pkg::BK_MONO) ? mono_word : val_reg;
        out_byte     = '0;
        byte_valid   = 1'b0;
        status       = whct_pkg::ST_OK;
        status_valid = 1'b0;
        last         = last_beat;
        unique case (kind_reg)
            whct_pkg::BK_STATUS:
            begin
                status       = val_reg[3:0];
                status_valid = 1'b1;
            end
            whct_pkg::BK_NONE:
            begin
                last = 1'b0;
            end
            default:
            begin
                out_byte   = src_word[{idx_reg[1:0], 3'b000} +: 8];
                byte_valid = 1'b1;
            end
        endcase
    end

endmodule

>>> dv/tb_wav_header_check_and_transform_top.sv
// Testbench for the WAV header check and transform block: one stream through every mode.
`timescale 1ns / 100ps

module tb_wav_header_check_and_transform_top;

    typedef struct {
        logic [7:0] ob;
        logic       bv;
        logic [3:0] st;
        logic       sv;
        logic       lst;
    } wav_res_t;

    // Mode value with no function of its own, acts as check only
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       end_of_stream;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [3:0] status;
    logic       status_valid;
    logic       last;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_data;

    wav_header_check_and_transform_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_stream(end_of_stream),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .byte_valid   (byte_valid),
        .status       (status),
        .status_valid (status_valid),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Clock, 2 ns period
    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Model state of the stream parser
    logic [33:0] pos_cnt;
    logic [31:0] h_riff, h_fmt_size, h_rate, h_brate, h_data;
    logic [15:0] h_type, h_chan, h_align, h_bits;
    logic [33:0] body_cnt;
    logic [31:0] extra_cnt;
    logic [7:0]  low_hold;
    logic        stopped;
    logic [2:0]  cur_mode;

    wav_res_t    pending_q[$];
    int          n_fail;
    int          n_words_in;
    int          n_words_out;
    bit          calm;

    function automatic void push_byte(logic [7:0] b);
        wav_res_t r;
        r.ob = b; r.bv = 1'b1; r.st = whct_pkg::ST_OK; r.sv = 1'b0; r.lst = 1'b0;
        pending_q.push_back(r);
    endfunction

    function automatic void push_status(logic [3:0] code);
        wav_res_t r;
        r.ob = 8'd0; r.bv = 1'b0; r.st = code; r.sv = 1'b1; r.lst = 1'b0;
        pending_q.push_back(r);
    endfunction

    function automatic void push_word(logic [31:0] v, int nb);
        for (int k = 0; k < nb; k++)
            push_byte(v[8*k +: 8]);
    endfunction

    // Mono rewrite of the header, sent as 40 bytes
    function automatic void push_mono_hdr();
        logic st2;
        st2 = (h_chan == 16'd2);
        push_word(st2 ? h_riff - (h_data >> 1) : h_riff, 4);
        push_word(whct_pkg::TAG_WAVE, 4);
        push_word(whct_pkg::TAG_FMT, 4);
        push_word(h_fmt_size, 4);
        push_word({16'd0, h_type}, 2);
        push_word(32'd1, 2);
        push_word(h_rate, 4);
        push_word(st2 ? h_brate >> 1 : h_brate, 4);
        push_word(st2 ? {16'd0, h_align >> 1} : {16'd0, h_align}, 2);
        push_word({16'd0, h_bits}, 2);
        push_word(whct_pkg::TAG_DATA, 4);
        push_word(st2 ? h_data >> 1 : h_data, 4);
    endfunction

    // One header byte; returns the error code or ok
    function automatic logic [3:0] hdr_byte_step(int i, logic [7:0] b, logic [2:0] m);
        logic [3:0]  err;
        logic [63:0] prod;
        int          sh;
        err = whct_pkg::ST_OK;
        if (i <= 4)
        begin
            if (b != whct_pkg::TAG_RIFF[8*(i-1) +: 8]) err = whct_pkg::ST_RIFF;
        end
        else if (i <= 8)
            h_riff[8*(i-5) +: 8] = b;
        else if (i <= 12)
        begin
            if (b != whct_pkg::TAG_WAVE[8*(i-9) +: 8]) err = whct_pkg::ST_WAVE;
        end
        else if (i <= 16)
        begin
            if (b != whct_pkg::TAG_FMT[8*(i-13) +: 8]) err = whct_pkg::ST_FMT_TAG;
        end
        else if (i <= 20)
            h_fmt_size[8*(i-17) +: 8] = b;
        else if (i <= 22)
        begin
            if (i == 21 && h_fmt_size != 32'd16) err = whct_pkg::ST_FMT_SIZE;
            else h_type[8*(i-21) +: 8] = b;
        end
        else if (i <= 24)
        begin
            if (i == 23 && h_type != 16'd1) err = whct_pkg::ST_TYPE;
            else h_chan[8*(i-23) +: 8] = b;
        end
        else if (i <= 28)
        begin
            if (i == 25 && h_chan != 16'd1 && h_chan != 16'd2) err = whct_pkg::ST_CHANNELS;
            else h_rate[8*(i-25) +: 8] = b;
        end
        else if (i <= 32)
            h_brate[8*(i-29) +: 8] = b;
        else if (i <= 34)
            h_align[8*(i-33) +: 8] = b;
        else if (i <= 36)
        begin
            prod = 64'(h_rate) * 64'(h_align);
            if (i == 35 && prod != 64'(h_brate)) err = whct_pkg::ST_BYTERATE;
            else h_bits[8*(i-35) +: 8] = b;
        end
        else if (i <= 40)
        begin
            if (i == 37 && h_bits != 16'd8 && h_bits != 16'd16) err = whct_pkg::ST_BITS;
            else if (i == 37 && 32'(h_bits / 16'd8) * 32'(h_chan) != 32'(h_align))
                err = whct_pkg::ST_ALIGN;
            else if (b != whct_pkg::TAG_DATA[8*(i-37) +: 8]) err = whct_pkg::ST_DATA_TAG;
        end
        else
            h_data[8*(i-41) +: 8] = b;
        if (err != whct_pkg::ST_OK)
            return err;

        // Pass-through and rewrite of header bytes
        if (i <= 4)
        begin
            if (m != whct_pkg::MODE_CHECK) push_byte(b);
        end
        else if (i >= 25 && i <= 32)
        begin
            if (m == whct_pkg::MODE_VOLUME)
                push_byte(b);
            else if ((m == whct_pkg::MODE_HALVE || m == whct_pkg::MODE_DOUBLE)
                    && (i == 28 || i == 32))
            begin
                sh = (i == 28) ? 0 : 1;
                if (sh == 0)
                    push_word(m == whct_pkg::MODE_HALVE ? h_rate >> 1 : h_rate << 1, 4);
                else
                    push_word(m == whct_pkg::MODE_HALVE ? h_brate >> 1 : h_brate << 1, 4);
            end
        end
        else if (m == whct_pkg::MODE_HALVE || m == whct_pkg::MODE_DOUBLE
                || m == whct_pkg::MODE_VOLUME)
            push_byte(b);
        else if ((m == whct_pkg::MODE_LEFT || m == whct_pkg::MODE_RIGHT) && i == 44)
            push_mono_hdr();
        return whct_pkg::ST_OK;
    endfunction

    // One byte after the header: data area or trailing bytes
    function automatic void body_byte_step(logic [33:0] i, logic [7:0] b, logic [2:0] m);
        logic [33:0] k;
        logic        mono;
        logic        eight;
        int          s;
        int          u;
        k = i - 34'd45;
        mono = (h_chan != 16'd2);
        eight = (h_bits == 16'd8);
        if (i - whct_pkg::HDR_LEN <= 34'(h_data))
        begin
            if (m == whct_pkg::MODE_HALVE || m == whct_pkg::MODE_DOUBLE)
                push_byte(b);
            else if (m == whct_pkg::MODE_LEFT)
            begin
                if (mono || (eight ? k[0] == 1'b0 : k[1:0] < 2'd2)) push_byte(b);
            end
            else if (m == whct_pkg::MODE_RIGHT)
            begin
                if (mono || (eight ? k[0] == 1'b1 : k[1:0] >= 2'd2)) push_byte(b);
            end
            else if (m == whct_pkg::MODE_VOLUME)
            begin
                if (eight)
                    push_byte(b >> 3);
                else if (k[0] == 1'b0)
                    low_hold = b;
                else
                begin
                    s = $signed({b, low_hold});
                    u = s / 8;
                    push_byte(u[7:0]);
                    push_byte(u[15:8]);
                end
            end
        end
        else
        begin
            if (extra_cnt != 32'hFFFF_FFFF) extra_cnt++;
            if (m != whct_pkg::MODE_CHECK) push_byte(b);
        end
    endfunction

    // Expected results of one accepted input word
    function automatic void predict_word(logic [7:0] b, logic eos);
        logic [2:0] m;
        logic [3:0] code;
        int         n0;
        m = (cur_mode > whct_pkg::MODE_VOLUME) ? whct_pkg::MODE_CHECK : cur_mode;
        n0 = pending_q.size();
        if (stopped)
            return;
        if (eos)
        begin
            if (pos_cnt <= whct_pkg::HDR_LEN) code = whct_pkg::ST_SHORT_HDR;
            else if (body_cnt < 34'(h_data)) code = whct_pkg::ST_SHORT_DATA;
            else if (64'(h_riff) != 64'd36 + 64'(h_data) + 64'(extra_cnt))
                code = whct_pkg::ST_FILE_SIZE;
            else code = whct_pkg::ST_OK;
            push_status(code);
            stopped = 1'b1;
        end
        else if (pos_cnt <= whct_pkg::HDR_LEN)
        begin
            code = hdr_byte_step(int'(pos_cnt), b, m);
            if (code != whct_pkg::ST_OK)
            begin
                push_status(code);
                stopped = 1'b1;
            end
            else if (pos_cnt < whct_pkg::POS_MAX)
                pos_cnt++;
        end
        else
        begin
            body_byte_step(pos_cnt, b, m);
            if (body_cnt < whct_pkg::POS_MAX) body_cnt++;
            if (pos_cnt < whct_pkg::POS_MAX) pos_cnt++;
        end
        if (pending_q.size() > n0)
            pending_q[$].lst = 1'b1;
    endfunction

    // Result side: random stalls, compare each accepted word
    int stall_left;
    always
    begin
        wav_res_t   e;
        logic       fire;
        logic [7:0] a_ob;
        logic       a_bv, a_sv, a_lst;
        logic [3:0] a_st;
        @(negedge clk);
        if (!rst_n || calm)
            out_ready = 1'b1;
        else if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else if ($urandom_range(7) == 0)
        begin
            out_ready = 1'b0;
            stall_left = $urandom_range(1, 6) - 1;
        end
        else
            out_ready = 1'b1;
        #0.5;
        fire = out_valid && out_ready && rst_n;
        a_ob = out_byte; a_bv = byte_valid; a_st = status; a_sv = status_valid; a_lst = last;
        @(posedge clk);
        if (fire)
        begin
            n_words_out++;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result word byte=%h bv=%b status=%0d sv=%b last=%b",
                         $time, a_ob, a_bv, a_st, a_sv, a_lst);
                n_fail++;
            end
            else
            begin
                e = pending_q.pop_front();
                if (a_ob !== e.ob || a_bv !== e.bv || a_st !== e.st || a_sv !== e.sv ||
                    a_lst !== e.lst)
                begin
                    $display("%0t: mismatch exp byte=%h bv=%b status=%0d sv=%b last=%b",
                             $time, e.ob, e.bv, e.st, e.sv, e.lst);
                    $display("%0t:          got byte=%h bv=%b status=%0d sv=%b last=%b",
                             $time, a_ob, a_bv, a_st, a_sv, a_lst);
                    n_fail++;
                end
            end
        end
    end

    // Send one input word, holding it until taken
    task automatic send_word(logic [7:0] b, logic eos);
        if (!calm && $urandom_range(3) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6) - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_byte = b;
        end_of_stream = eos;
        forever
        begin
            #0.5;
            if (in_ready)
            begin
                predict_word(b, eos);
                n_words_in++;
                @(posedge clk);
                break;
            end
            @(negedge clk);
        end
    endtask

    // Write the mode register once the block has drained
    task automatic write_mode(logic [2:0] m);
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_q.size() == 0);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = m;
        forever
        begin
            #0.5;
            if (cfg_ready)
            begin
                cur_mode = m;
                @(posedge clk);
                break;
            end
            @(negedge clk);
        end
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Canonical header: stereo, 16 bit, 44100 Hz, 60 data bytes, 15 trailing bytes
    localparam int HDR_ROWS = 44;
    logic [7:0] hdr_table [HDR_ROWS] = '{
        8'h52, 8'h49, 8'h46, 8'h46,  8'h6F, 8'h00, 8'h00, 8'h00,
        8'h57, 8'h41, 8'h56, 8'h45,  8'h66, 8'h6D, 8'h74, 8'h20,
        8'h10, 8'h00, 8'h00, 8'h00,  8'h01, 8'h00, 8'h02, 8'h00,
        8'h44, 8'hAC, 8'h00, 8'h00,  8'h10, 8'hB1, 8'h02, 8'h00,
        8'h04, 8'h00, 8'h10, 8'h00,  8'h64, 8'h61, 8'h74, 8'h61,
        8'h3C, 8'h00, 8'h00, 8'h00
    };

    localparam int BODY_LEN = 75;
    localparam int N_PHASES = 7;
    logic [2:0] phase_mode [N_PHASES] = '{
        whct_pkg::MODE_HALVE, whct_pkg::MODE_DOUBLE, whct_pkg::MODE_LEFT,
        whct_pkg::MODE_RIGHT, whct_pkg::MODE_VOLUME, MODE_UNUSED, whct_pkg::MODE_CHECK
    };

    initial
    begin
        logic [2:0] hdr_mode;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_byte = 8'd0;
        end_of_stream = 1'b0;
        out_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_data = whct_pkg::MODE_CHECK;
        calm = 1'b0;
        n_fail = 0;
        n_words_in = 0;
        n_words_out = 0;
        stall_left = 0;
        pos_cnt = 34'd1;
        {h_riff, h_fmt_size, h_rate, h_brate, h_data} = '0;
        {h_type, h_chan, h_align, h_bits} = '0;
        body_cnt = '0;
        extra_cnt = '0;
        low_hold = '0;
        stopped = 1'b0;
        cur_mode = whct_pkg::MODE_CHECK;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Header under a random mode
        hdr_mode = 3'($urandom_range(0, 5));
        write_mode(hdr_mode);
        for (int r = 0; r < HDR_ROWS; r++)
            send_word(hdr_table[r], 1'b0);

        // Body: 60 data bytes then 15 trailing bytes, mode changed per phase
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_mode(phase_mode[p]);
            if (p == N_PHASES - 1) calm = 1'b1;
            for (int j = 0; j < BODY_LEN / N_PHASES + (p < BODY_LEN % N_PHASES ? 1 : 0);
                 j++)
                send_word(8'($urandom_range(0, 255)), 1'b0);
        end
        send_word(8'($urandom_range(0, 255)), 1'b1);

        @(negedge clk);
        in_valid = 1'b0;
        wait (pending_q.size() == 0);
        repeat (50) @(posedge clk);
        $display("Sent one stereo 16-bit stream (%0d input words, header mode %0d)",
                 n_words_in, hdr_mode);
        $display("through all body modes and end of stream; %0d result words checked",
                 n_words_out);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #500000;
        $display("Timeout at %0t", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule
